FILE: rtl/bads_pkg.sv
`default_nettype none

package bads_pkg;

    // image geometry
    localparam int OUT_DIM    = 32;
    localparam int BLOCK_DIM  = 8;
    localparam int IMG_DIM    = OUT_DIM * BLOCK_DIM;
    localparam int BLOCK_AREA = BLOCK_DIM * BLOCK_DIM;

    // block area must be a power of two, the average is a shift
    localparam int AREA_SHIFT = $clog2(BLOCK_AREA);

    // pixel sample taken from bits 31:16 of the word
    localparam int SAMPLE_LO = 16;
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = SAMPLE_W + AREA_SHIFT;

    // counter widths
    localparam int SUB_W  = (BLOCK_DIM > 1) ? $clog2(BLOCK_DIM) : 1;
    localparam int BAND_W = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;

    localparam logic [SUB_W-1:0]  LAST_SUB  = SUB_W'(BLOCK_DIM - 1);
    localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(OUT_DIM - 1);

    // result field widths
    localparam int VALUE_W = 8;
    localparam int CELL_W  = 5;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic        frame_start;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] cell_value;
        logic [CELL_W-1:0]  cell_row;
        logic [CELL_W-1:0]  cell_col;
        logic               frame_last;
    } t_out_item;

    // current pixel position, frame start already applied
    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [BAND_W-1:0] cell_row;
        logic              block_end;
        logic              frame_last;
    } t_pos_info;

    // accumulator bank control
    typedef struct packed {
        logic              update;
        logic              clear_all;
        logic              block_end;
        logic [BAND_W-1:0] band;
    } t_acc_ctl;

    // low bits of a cell index, zero extended where the index is narrow
    function automatic logic [CELL_W-1:0] to_cell(input logic [BAND_W-1:0] idx);
        logic [BAND_W+CELL_W-1:0] wide;
        wide = {{CELL_W{1'b0}}, idx};
        return wide[CELL_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bads_pos.sv
`default_nettype none

module bads_pos
    import bads_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_advance,
    input  wire logic      i_frame_start,
    output t_pos_info      o_pos
);

    logic [SUB_W-1:0]  r_sub_col, n_sub_col;
    logic [SUB_W-1:0]  r_sub_row, n_sub_row;
    logic [BAND_W-1:0] r_band, n_band;
    logic [BAND_W-1:0] r_cell_row, n_cell_row;

    logic [SUB_W-1:0]  w_sub_col, w_sub_row;
    logic [BAND_W-1:0] w_band, w_cell_row;
    logic              w_col_wrap, w_band_wrap, w_row_wrap;

    // a frame start puts the pixel at the origin
    always_comb begin
        w_sub_col  = i_frame_start ? '0 : r_sub_col;
        w_sub_row  = i_frame_start ? '0 : r_sub_row;
        w_band     = i_frame_start ? '0 : r_band;
        w_cell_row = i_frame_start ? '0 : r_cell_row;
    end

    assign w_col_wrap  = (w_sub_col == LAST_SUB);
    assign w_band_wrap = w_col_wrap && (w_band == LAST_BAND);
    assign w_row_wrap  = w_band_wrap && (w_sub_row == LAST_SUB);

    always_comb begin
        o_pos.band       = w_band;
        o_pos.cell_row   = w_cell_row;
        o_pos.block_end  = w_col_wrap && (w_sub_row == LAST_SUB);
        o_pos.frame_last = w_row_wrap && (w_cell_row == LAST_BAND);
    end

    // raster step to the next pixel
    always_comb begin
        n_sub_col  = w_col_wrap ? '0 : w_sub_col + SUB_W'(1);
        n_band     = w_band;
        n_sub_row  = w_sub_row;
        n_cell_row = w_cell_row;
        if (w_col_wrap) begin
            n_band = (w_band == LAST_BAND) ? '0 : w_band + BAND_W'(1);
        end
        if (w_band_wrap) begin
            n_sub_row = (w_sub_row == LAST_SUB) ? '0 : w_sub_row + SUB_W'(1);
        end
        if (w_row_wrap) begin
            n_cell_row = (w_cell_row == LAST_BAND) ? '0 : w_cell_row + BAND_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_col  <= '0;
            r_sub_row  <= '0;
            r_band     <= '0;
            r_cell_row <= '0;
        end else if (i_advance) begin
            r_sub_col  <= n_sub_col;
            r_sub_row  <= n_sub_row;
            r_band     <= n_band;
            r_cell_row <= n_cell_row;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bads_acc.sv
`default_nettype none

module bads_acc
    import bads_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_acc_ctl            i_ctl,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    output logic      [SUM_W-1:0]    o_sum
);

    logic [SUM_W-1:0] r_acc [OUT_DIM];
    logic [OUT_DIM-1:0] r_valid, n_valid;
    logic [SUM_W-1:0] w_old;

    // an entry that is not valid reads as zero
    always_comb begin
        if (i_ctl.clear_all || !r_valid[i_ctl.band]) begin
            w_old = '0;
        end else begin
            w_old = r_acc[i_ctl.band];
        end
    end

    assign o_sum = w_old + SUM_W'(i_sample);

    always_comb begin
        n_valid = i_ctl.clear_all ? '0 : r_valid;
        n_valid[i_ctl.band] = !i_ctl.block_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.update) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.update) begin
            r_acc[i_ctl.band] <= o_sum;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/block_average_downscaler_unit.sv
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_stall    i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_stall  o_out_data (t_out_item)
//
// one pixel per cycle sustained while the output does not stall; a pixel
// is held in the input register, its result loads the output register
// the per-pixel path is one 22-bit add on the band accumulator
// reset is synchronous and active low; it empties both registers, zeroes
// the position and marks every band accumulator empty
// a stall on the output holds the result and backs up into the input
// only when the input register also holds a pixel
`default_nettype none

module block_average_downscaler_unit
    import bads_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    // input register
    logic                r_s1_valid, n_s1_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_frame_start;

    // result register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out;

    logic             w_advance;
    logic             w_in_xfer;
    t_pos_info        w_pos;
    t_acc_ctl         w_acc_ctl;
    logic [SUM_W-1:0] w_sum;

    // the held pixel moves on when the result slot is free or being emptied
    assign w_advance  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_advance;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_in_xfer) begin
            n_s1_valid = 1'b1;
        end else if (w_advance) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // only the upper half of the word is ever summed
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_sample      <= i_in_data.pixel_word[SAMPLE_LO +: SAMPLE_W];
            r_frame_start <= i_in_data.frame_start;
        end
    end

    // raster position of the held pixel
    bads_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_advance),
        .i_frame_start (r_frame_start),
        .o_pos         (w_pos)
    );

    // band accumulators, cleared at frame start and after each block
    always_comb begin
        w_acc_ctl.update    = w_advance;
        w_acc_ctl.clear_all = r_frame_start;
        w_acc_ctl.block_end = w_pos.block_end;
        w_acc_ctl.band      = w_pos.band;
    end

    bads_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_acc_ctl),
        .i_sample (r_sample),
        .o_sum    (w_sum)
    );

    // a result is loaded only by a pixel that closes a block
    always_comb begin
        if (w_advance) begin
            n_out_valid = w_pos.block_end;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // average is the block sum shifted down by the block area, low byte kept
    always_ff @(posedge i_clk) begin
        if (w_advance && w_pos.block_end) begin
            r_out.cell_value <= VALUE_W'(w_sum >> AREA_SHIFT);
            r_out.cell_row   <= to_cell(w_pos.cell_row);
            r_out.cell_col   <= to_cell(w_pos.band);
            r_out.frame_last <= w_pos.frame_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the last cell of a frame sits in the bottom right corner
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_last |->
            o_out_data.cell_row == to_cell(LAST_BAND) &&
            o_out_data.cell_col == to_cell(LAST_BAND))
        else $error("frame_last away from the last cell");

    // the input backs up only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without an output stall");

    // a new result always comes from a pixel that moved on
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_advance))
        else $error("result appeared without a processed pixel");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench
    import bads_pkg::*;
();

    // pixels in one band of block rows
    localparam int BAND_PIXELS  = IMG_DIM * BLOCK_DIM;

    // receiver hold-off length, idle cycles allowed before giving up
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    block_average_downscaler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // own copy of the downscaler state: band sums and next pixel position
    logic [SUM_W-1:0] band_acc [OUT_DIM];
    int               pix_col;
    int               pix_row;

    // cells predicted but not yet seen on the output, oldest first
    t_out_item        expected_cells [$];

    // idle percentages per side and the long receiver hold-off
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    logic             hold_on = 1'b0;
    event             hold_kick;

    // run statistics
    int               mismatches  = 0;
    int               n_pixels    = 0;
    int               n_starts    = 0;
    int               n_cells     = 0;
    int               n_frame_end = 0;
    int               quiet_cycles = 0;

    // accumulate one accepted pixel, queue the cell it completes if any
    function automatic void accumulate_pixel(input logic [31:0] word, input logic start);
        int               band;
        logic [SUM_W-1:0] avg;
        t_out_item        pred_cell;
        if (start) begin
            pix_col = 0;
            pix_row = 0;
            foreach (band_acc[k]) band_acc[k] = '0;
        end
        band = pix_col / BLOCK_DIM;
        band_acc[band] = band_acc[band] + SUM_W'(word[SAMPLE_LO +: SAMPLE_W]);
        if ((pix_row % BLOCK_DIM) == BLOCK_DIM - 1 &&
            (pix_col % BLOCK_DIM) == BLOCK_DIM - 1) begin
            // truncating average, only the low byte survives
            avg                  = band_acc[band] / BLOCK_AREA;
            pred_cell.cell_value = avg[VALUE_W-1:0];
            pred_cell.cell_row   = CELL_W'(pix_row / BLOCK_DIM);
            pred_cell.cell_col   = CELL_W'(band);
            pred_cell.frame_last = (pix_row == IMG_DIM - 1) && (pix_col == IMG_DIM - 1);
            expected_cells.push_back(pred_cell);
            band_acc[band] = '0;
        end
        // raster advance, wraps into the next frame without a mark
        pix_col++;
        if (pix_col == IMG_DIM) begin
            pix_col = 0;
            pix_row = (pix_row + 1) % IMG_DIM;
        end
    endfunction

    // offer one pixel, with random gaps before it, and predict on the transfer
    task automatic send_pixel(input logic [31:0] word, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{pixel_word: word, frame_start: start};
        do @(posedge i_clk); while (o_in_stall);
        accumulate_pixel(word, start);
        n_pixels++;
        if (start) n_starts++;
    endtask

    // sender pauses until every predicted cell has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_cells.size() != 0) @(posedge i_clk);
    endtask

    // a partial frame, left for the next frame start to drop
    task automatic test_frame_restart();
        int k;
        int len;
        len = $urandom_range(1, IMG_DIM);
        for (k = 0; k < len; k++) send_pixel($urandom, k == 0);
    endtask

    // one band of fixed patterns: zero and full-scale samples, an average
    // of exactly 255, one of 256 that wraps to zero, alternating extremes
    task automatic test_band_extremes();
        int          k;
        int          band;
        logic [31:0] word;
        for (k = 0; k < BAND_PIXELS; k++) begin
            band = (k % IMG_DIM) / BLOCK_DIM;
            case (band % 6)
                0: word = 32'h0000_FFFF;
                1: word = 32'hFFFF_0000;
                2: word = {16'h0100, 16'($urandom)};
                3: word = (k % 2) ? 32'hFFFF_FFFF : 32'h0000_0000;
                4: word = {16'h00FF, 16'($urandom)};
                default: word = $urandom;
            endcase
            send_pixel(word, k == 0);
        end
        wait_drained();
    endtask

    // output held off from the last pixel row of the first cell row so the block backs up
    task automatic test_backpressure();
        int k;
        for (k = 0; k < BAND_PIXELS; k++) begin
            if (k == BAND_PIXELS - IMG_DIM) -> hold_kick;
            send_pixel($urandom, k == 0);
        end
        wait_drained();
    endtask

    // one band of random pixels after a frame start
    task automatic test_random_band();
        int k;
        for (k = 0; k < BAND_PIXELS; k++) send_pixel($urandom, k == 0);
        wait_drained();
    endtask

    // long receiver hold-off, counted here
    always begin
        @(hold_kick);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // receiver stall: random idling plus the hold-off
    always @(posedge i_clk) begin
        i_out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
    end

    task automatic note_mismatch(input string what, input t_out_item want, input t_out_item got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $write("error: %s: expected value %02h row %0d col %0d last %0b, ",
                   what, want.cell_value, want.cell_row, want.cell_col, want.frame_last);
            $display("got value %02h row %0d col %0d last %0b",
                     got.cell_value, got.cell_row, got.cell_col, got.frame_last);
        end
    endtask

    // result checker: every output transfer against the oldest prediction
    t_out_item want_cell;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_cells.size() == 0) begin
                note_mismatch("cell with nothing predicted", '0, o_out_data);
            end else begin
                want_cell = expected_cells.pop_front();
                n_cells++;
                if (want_cell.frame_last) n_frame_end++;
                if (o_out_data.cell_value !== want_cell.cell_value)
                    note_mismatch("cell_value", want_cell, o_out_data);
                if (o_out_data.cell_row !== want_cell.cell_row)
                    note_mismatch("cell_row", want_cell, o_out_data);
                if (o_out_data.cell_col !== want_cell.cell_col)
                    note_mismatch("cell_col", want_cell, o_out_data);
                if (o_out_data.frame_last !== want_cell.frame_last)
                    note_mismatch("frame_last", want_cell, o_out_data);
            end
        end
    end

    // watchdog: too long without any transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("block_average_downscaler_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (band_acc[k]) band_acc[k] = '0;
        pix_col = 0;
        pix_row = 0;

        // synchronous reset, held low before the first test
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles more rarely than the receiver
        send_idle_pct = 31;
        recv_idle_pct = 48;
        test_frame_restart();
        test_band_extremes();

        // roles swapped
        send_idle_pct = 48;
        recv_idle_pct = 31;
        test_backpressure();

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_band();

        // let the pipeline settle, nothing more may appear
        repeat (8) @(posedge i_clk);

        $display("run: %0d pixels with %0d frame starts, %0d cells checked, %0d frame ends",
                 n_pixels, n_starts, n_cells, n_frame_end);
        $display("run: idle mixes on both sides, a dropped partial frame and output hold-off");
        if (mismatches == 0) begin
            $display("block_average_downscaler_unit: match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("block_average_downscaler_unit: mismatch");
        end
        $finish;
    end

endmodule
